/* sv/ddws_pkg.sv */
// Shared types, widths, codes and fixed-point helpers for the wheel speed PID block.
// No dependencies; every other file of the block imports this package.
package ddws_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 32;
  localparam int UCFG_W     = 31;
  localparam int ACTION_W   = 2;
  localparam int PAT_W      = 4;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Serial multiplier operand and product widths, and the wide accumulate width.
  localparam int MUL_W  = Q_W + 1;
  localparam int PROD_W = 2 * Q_W;
  localparam int WIDE_W = PROD_W + 4;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic [UCFG_W-1:0]       ucfg_t;
  typedef logic [ACTION_W-1:0]     action_t;
  typedef logic [PAT_W-1:0]        pattern_t;
  typedef logic [DUTY_W-1:0]       duty_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Input word actions.
  localparam action_t ACT_RIGHT_EDGE = 2'd0;
  localparam action_t ACT_LEFT_EDGE  = 2'd1;
  localparam action_t ACT_TICK       = 2'd2;
  localparam action_t ACT_MOVE       = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t REG_COEF_NOW     = 3'd0;
  localparam cfg_idx_t REG_COEF_PREV    = 3'd1;
  localparam cfg_idx_t REG_COEF_PREV2   = 3'd2;
  localparam cfg_idx_t REG_INV_RADIUS   = 3'd3;
  localparam cfg_idx_t REG_HALF_TRACK   = 3'd4;
  localparam cfg_idx_t REG_SPEED_SCALE  = 3'd5;

  // H-bridge direction patterns.
  localparam pattern_t PAT_BOTH_FWD  = 4'h5;
  localparam pattern_t PAT_RIGHT_REV = 4'h6;
  localparam pattern_t PAT_BOTH_REV  = 4'hA;
  localparam pattern_t PAT_LEFT_REV  = 4'h9;

  // Reset values of the geometry registers.
  localparam ucfg_t INV_RADIUS_RST = 31'd819200;
  localparam ucfg_t HALF_TRACK_RST = 31'd65536;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Sign-extend a Q value to the wide accumulate width.
  function automatic wide_t sext_q(input q_t x);
    sext_q = {{(WIDE_W-Q_W){x[Q_W-1]}}, x};
  endfunction

  // Saturate a wide signed value to the Q range.
  function automatic q_t sat_q(input wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    lo_lim = {{(WIDE_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
    if (v > hi_lim) begin
      sat_q = Q_MAX;
    end else if (v < lo_lim) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

/* sv/ddws_if.sv */
// Valid/ready channel interfaces for the input, result and configuration words.
// Depends on ddws_pkg for the payload types.
interface ddws_in_if;
  import ddws_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  q_t      lin_speed;
  q_t      ang_speed;
  modport source (output valid, action, lin_speed, ang_speed, input ready);
  modport sink (input valid, action, lin_speed, ang_speed, output ready);
endinterface

interface ddws_out_if;
  import ddws_pkg::*;
  logic     valid;
  logic     ready;
  pattern_t bridge_pattern;
  duty_t    duty_right;
  duty_t    duty_left;
  modport source (output valid, bridge_pattern, duty_right, duty_left, input ready);
  modport sink (input valid, bridge_pattern, duty_right, duty_left, output ready);
endinterface

interface ddws_cfg_if;
  import ddws_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/diff_drive_wheel_speed_pid_top.sv */
// Differential-drive wheel speed controller with one incremental PID per wheel.
// Encoder edge words are counted while idle. Every product goes through one shared bit-serial
// multiplier in the steps start, bit steps, done and use; a sample tick takes 2 products,
// a move 8 products plus the error, control and output steps.
// One word is worked on at a time; a result may wait in the output register.
// Synchronous active-low reset clears all control state and restores register defaults.
module diff_drive_wheel_speed_pid_top (
  input logic         clk,
  input logic         rst_n,
  ddws_in_if.sink     in_bus,
  ddws_out_if.source  out_bus,
  ddws_cfg_if.sink    cfg_bus
);
  import ddws_pkg::*;

  // Sequencer states.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] S_START = 3'd1;
  localparam logic [ST_W-1:0] S_WAIT  = 3'd2;
  localparam logic [ST_W-1:0] S_POST  = 3'd3;
  localparam logic [ST_W-1:0] S_ERR   = 3'd4;
  localparam logic [ST_W-1:0] S_CTL   = 3'd5;
  localparam logic [ST_W-1:0] S_OUT   = 3'd6;

  // Product being formed by the multiplier.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_TICK_R = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK_L = 3'd1;
  localparam logic [OP_W-1:0] OP_LIN    = 3'd2;
  localparam logic [OP_W-1:0] OP_ANG    = 3'd3;
  localparam logic [OP_W-1:0] OP_CN     = 3'd4;
  localparam logic [OP_W-1:0] OP_CP     = 3'd5;
  localparam logic [OP_W-1:0] OP_CP2    = 3'd6;

  localparam q_t DUTY_MAX_Q = q_t'(2**DUTY_W - 1);

  // Integer part of a control value, clamped to the duty range.
  function automatic duty_t duty_of(input q_t ctl);
    q_t whole;
    whole = ctl >>> FRAC_BITS;
    if (whole < 0) begin
      duty_of = '0;
    end else if (whole > DUTY_MAX_Q) begin
      duty_of = {DUTY_W{1'b1}};
    end else begin
      duty_of = whole[DUTY_W-1:0];
    end
  endfunction

  // Configuration registers.
  q_t    coef_now_r, coef_now_nxt;
  q_t    coef_prev_r, coef_prev_nxt;
  q_t    coef_prev2_r, coef_prev2_nxt;
  ucfg_t inv_wheel_radius_r, inv_wheel_radius_nxt;
  ucfg_t half_track_ratio_r, half_track_ratio_nxt;
  ucfg_t speed_scale_r, speed_scale_nxt;

  // Controller state.
  logic [Q_W-1:0] right_steps_r, right_steps_nxt;
  logic [Q_W-1:0] left_steps_r, left_steps_nxt;
  q_t right_speed_r, right_speed_nxt;
  q_t left_speed_r, left_speed_nxt;
  q_t right_control_r, right_control_nxt;
  q_t left_control_r, left_control_nxt;
  q_t right_err_one_r, right_err_one_nxt;
  q_t right_err_two_r, right_err_two_nxt;
  q_t left_err_one_r, left_err_one_nxt;
  q_t left_err_two_r, left_err_two_nxt;

  // Sequencer and working registers.
  logic [ST_W-1:0] state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic            side_r, side_nxt;
  q_t              lin_r, lin_nxt;
  q_t              ang_r, ang_nxt;
  wide_t           a_r, a_nxt;
  q_t              tgt_right_r, tgt_right_nxt;
  q_t              tgt_left_r, tgt_left_nxt;
  q_t              err_r, err_nxt;
  wide_t           acc_r, acc_nxt;

  // Output register.
  logic     out_valid_r, out_valid_nxt;
  pattern_t out_pattern_r, out_pattern_nxt;
  duty_t    out_duty_right_r, out_duty_right_nxt;
  duty_t    out_duty_left_r, out_duty_left_nxt;

  // Multiplier connections.
  logic                     mul_start;
  logic                     mul_done;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_product;
  wide_t                    prod_w;
  wide_t                    prod_shift;

  // Values of the wheel being updated.
  q_t       sel_target, sel_speed, sel_ctl, sel_e1, sel_e2;
  q_t       tick_speed;
  pattern_t pattern;
  logic     in_fire;
  logic     out_free;

  ddws_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // Handshakes and result port.
  assign in_bus.ready          = (state_r == S_IDLE);
  assign cfg_bus.ready         = 1'b1;
  assign in_fire               = in_bus.valid && in_bus.ready;
  assign out_free              = !out_valid_r || out_bus.ready;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.bridge_pattern = out_pattern_r;
  assign out_bus.duty_right    = out_duty_right_r;
  assign out_bus.duty_left     = out_duty_left_r;
  assign mul_start             = (state_r == S_START);

  // Product widened and rescaled by the fraction bits (floor).
  assign prod_w     = {{(WIDE_W-PROD_W){mul_product[PROD_W-1]}}, mul_product};
  assign prod_shift = prod_w >>> FRAC_BITS;

  // A step count times the scale saturates at the largest positive value.
  assign tick_speed = (|mul_product[PROD_W-1:Q_W-1]) ? Q_MAX : mul_product[Q_W-1:0];

  // Per-wheel selection.
  always_comb begin
    sel_target = side_r ? tgt_left_r : tgt_right_r;
    sel_speed  = side_r ? left_speed_r : right_speed_r;
    sel_ctl    = side_r ? left_control_r : right_control_r;
    sel_e1     = side_r ? left_err_one_r : right_err_one_r;
    sel_e2     = side_r ? left_err_two_r : right_err_two_r;
  end

  // Multiplier operands for each product.
  always_comb begin
    case (op_r)
      OP_TICK_R: begin
        mul_a = {1'b0, right_steps_r};
        mul_b = {{(MUL_W-UCFG_W){1'b0}}, speed_scale_r};
      end
      OP_TICK_L: begin
        mul_a = {1'b0, left_steps_r};
        mul_b = {{(MUL_W-UCFG_W){1'b0}}, speed_scale_r};
      end
      OP_LIN: begin
        mul_a = {lin_r[Q_W-1], lin_r};
        mul_b = {{(MUL_W-UCFG_W){1'b0}}, inv_wheel_radius_r};
      end
      OP_ANG: begin
        mul_a = {ang_r[Q_W-1], ang_r};
        mul_b = {{(MUL_W-UCFG_W){1'b0}}, half_track_ratio_r};
      end
      OP_CN: begin
        mul_a = {coef_now_r[Q_W-1], coef_now_r};
        mul_b = {err_r[Q_W-1], err_r};
      end
      OP_CP: begin
        mul_a = {coef_prev_r[Q_W-1], coef_prev_r};
        mul_b = {sel_e1[Q_W-1], sel_e1};
      end
      OP_CP2: begin
        mul_a = {coef_prev2_r[Q_W-1], coef_prev2_r};
        mul_b = {sel_e2[Q_W-1], sel_e2};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Direction pattern from the signs of the two wheel targets.
  always_comb begin
    case ({tgt_right_r[Q_W-1], tgt_left_r[Q_W-1]})
      2'b00:   pattern = PAT_BOTH_FWD;
      2'b10:   pattern = PAT_RIGHT_REV;
      2'b11:   pattern = PAT_BOTH_REV;
      default: pattern = PAT_LEFT_REV;
    endcase
  end

  // Configuration writes.
  always_comb begin
    coef_now_nxt         = coef_now_r;
    coef_prev_nxt        = coef_prev_r;
    coef_prev2_nxt       = coef_prev2_r;
    inv_wheel_radius_nxt = inv_wheel_radius_r;
    half_track_ratio_nxt = half_track_ratio_r;
    speed_scale_nxt      = speed_scale_r;
    if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        REG_COEF_NOW:    coef_now_nxt         = cfg_bus.data;
        REG_COEF_PREV:   coef_prev_nxt        = cfg_bus.data;
        REG_COEF_PREV2:  coef_prev2_nxt       = cfg_bus.data;
        REG_INV_RADIUS:  inv_wheel_radius_nxt = cfg_bus.data[UCFG_W-1:0];
        REG_HALF_TRACK:  half_track_ratio_nxt = cfg_bus.data[UCFG_W-1:0];
        REG_SPEED_SCALE: speed_scale_nxt      = cfg_bus.data[UCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: step counting, speed sampling, wheel targets, the two PID updates and the result.
  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    side_nxt           = side_r;
    lin_nxt            = lin_r;
    ang_nxt            = ang_r;
    a_nxt              = a_r;
    tgt_right_nxt      = tgt_right_r;
    tgt_left_nxt       = tgt_left_r;
    err_nxt            = err_r;
    acc_nxt            = acc_r;
    right_steps_nxt    = right_steps_r;
    left_steps_nxt     = left_steps_r;
    right_speed_nxt    = right_speed_r;
    left_speed_nxt     = left_speed_r;
    right_control_nxt  = right_control_r;
    left_control_nxt   = left_control_r;
    right_err_one_nxt  = right_err_one_r;
    right_err_two_nxt  = right_err_two_r;
    left_err_one_nxt   = left_err_one_r;
    left_err_two_nxt   = left_err_two_r;
    out_pattern_nxt    = out_pattern_r;
    out_duty_right_nxt = out_duty_right_r;
    out_duty_left_nxt  = out_duty_left_r;
    out_valid_nxt      = out_valid_r && !out_bus.ready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_bus.action)
            ACT_RIGHT_EDGE: right_steps_nxt = right_steps_r + 1'b1;
            ACT_LEFT_EDGE:  left_steps_nxt  = left_steps_r + 1'b1;
            ACT_TICK: begin
              op_nxt    = OP_TICK_R;
              state_nxt = S_START;
            end
            default: begin
              lin_nxt   = in_bus.lin_speed;
              ang_nxt   = in_bus.ang_speed;
              op_nxt    = OP_LIN;
              state_nxt = S_START;
            end
          endcase
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mul_done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        case (op_r)
          OP_TICK_R: begin
            right_speed_nxt = tick_speed;
            op_nxt          = OP_TICK_L;
            state_nxt       = S_START;
          end
          OP_TICK_L: begin
            left_speed_nxt  = tick_speed;
            right_steps_nxt = '0;
            left_steps_nxt  = '0;
            state_nxt       = S_IDLE;
          end
          OP_LIN: begin
            a_nxt     = prod_shift;
            op_nxt    = OP_ANG;
            state_nxt = S_START;
          end
          OP_ANG: begin
            tgt_right_nxt = sat_q(a_r + prod_shift);
            tgt_left_nxt  = sat_q(a_r - prod_shift);
            side_nxt      = 1'b0;
            state_nxt     = S_ERR;
          end
          OP_CN: begin
            acc_nxt   = prod_w;
            op_nxt    = OP_CP;
            state_nxt = S_START;
          end
          OP_CP: begin
            acc_nxt   = acc_r + prod_w;
            op_nxt    = OP_CP2;
            state_nxt = S_START;
          end
          default: begin
            acc_nxt   = acc_r + prod_w;
            state_nxt = S_CTL;
          end
        endcase
      end
      S_ERR: begin
        err_nxt   = sat_q(sext_q(sel_target) - sext_q(sel_speed));
        op_nxt    = OP_CN;
        state_nxt = S_START;
      end
      S_CTL: begin
        // Apply the control increment and age the error history.
        if (side_r) begin
          left_control_nxt = sat_q(sext_q(sel_ctl) + (acc_r >>> FRAC_BITS));
          left_err_two_nxt = left_err_one_r;
          left_err_one_nxt = err_r;
          state_nxt        = S_OUT;
        end else begin
          right_control_nxt = sat_q(sext_q(sel_ctl) + (acc_r >>> FRAC_BITS));
          right_err_two_nxt = right_err_one_r;
          right_err_one_nxt = err_r;
          side_nxt          = 1'b1;
          state_nxt         = S_ERR;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_pattern_nxt    = pattern;
          out_duty_right_nxt = duty_of(right_control_r);
          out_duty_left_nxt  = duty_of(left_control_r);
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      out_valid_r        <= 1'b0;
      coef_now_r         <= '0;
      coef_prev_r        <= '0;
      coef_prev2_r       <= '0;
      inv_wheel_radius_r <= INV_RADIUS_RST;
      half_track_ratio_r <= HALF_TRACK_RST;
      speed_scale_r      <= '0;
      right_steps_r      <= '0;
      left_steps_r       <= '0;
      right_speed_r      <= '0;
      left_speed_r       <= '0;
      right_control_r    <= '0;
      left_control_r     <= '0;
      right_err_one_r    <= '0;
      right_err_two_r    <= '0;
      left_err_one_r     <= '0;
      left_err_two_r     <= '0;
    end else begin
      state_r            <= state_nxt;
      out_valid_r        <= out_valid_nxt;
      coef_now_r         <= coef_now_nxt;
      coef_prev_r        <= coef_prev_nxt;
      coef_prev2_r       <= coef_prev2_nxt;
      inv_wheel_radius_r <= inv_wheel_radius_nxt;
      half_track_ratio_r <= half_track_ratio_nxt;
      speed_scale_r      <= speed_scale_nxt;
      right_steps_r      <= right_steps_nxt;
      left_steps_r       <= left_steps_nxt;
      right_speed_r      <= right_speed_nxt;
      left_speed_r       <= left_speed_nxt;
      right_control_r    <= right_control_nxt;
      left_control_r     <= left_control_nxt;
      right_err_one_r    <= right_err_one_nxt;
      right_err_two_r    <= right_err_two_nxt;
      left_err_one_r     <= left_err_one_nxt;
      left_err_two_r     <= left_err_two_nxt;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    side_r           <= side_nxt;
    lin_r            <= lin_nxt;
    ang_r            <= ang_nxt;
    a_r              <= a_nxt;
    tgt_right_r      <= tgt_right_nxt;
    tgt_left_r       <= tgt_left_nxt;
    err_r            <= err_nxt;
    acc_r            <= acc_nxt;
    out_pattern_r    <= out_pattern_nxt;
    out_duty_right_r <= out_duty_right_nxt;
    out_duty_left_r  <= out_duty_left_nxt;
  end

endmodule

/* sv/ddws_serial_mul.sv */
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add into a
// right-shifting partial product. Depends on ddws_pkg for widths.
module ddws_serial_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ddws_pkg::MUL_W-1:0]    mcand,
  input  logic signed [ddws_pkg::MUL_W-1:0]    mplier,
  output logic                                 done,
  output logic signed [ddws_pkg::PROD_W-1:0]   product
);
  import ddws_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MUL_W - 1);

  logic signed [MUL_W-1:0] m_r;
  logic signed [MUL_W:0]   hi_r, hi_nxt;
  logic signed [MUL_W:0]   m_ext, addend, sum;
  logic [MUL_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic                    last_step;
  logic [2*MUL_W:0]        full;

  // One step: add the multiplicand when the low multiplier bit is set (subtract
  // it on the sign bit), then shift the partial product right by one.
  always_comb begin
    last_step = (cnt_r == LAST_CNT);
    m_ext     = {m_r[MUL_W-1], m_r};
    if (!lo_r[0]) begin
      addend = '0;
    end else if (last_step) begin
      addend = -m_ext;
    end else begin
      addend = m_ext;
    end
    sum = hi_r + addend;

    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt   = '0;
      lo_nxt   = mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = {sum[MUL_W], sum[MUL_W:1]};
      lo_nxt  = {sum[0], lo_r[MUL_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (start) begin
      m_r <= mcand;
    end
  end

  assign full    = {hi_r, lo_r};
  assign product = $signed(full[PROD_W-1:0]);
  assign done    = done_r;

endmodule
